// ----- rtl/core/sha256_pkg.sv -----
package sha256_pkg;

    localparam int BlockBytes = 64;
    localparam int BlockWords = 16;
    localparam int Rounds     = 64;
    localparam int HashWords  = 8;
    localparam int LenBytePos = 56;
    localparam logic [7:0] PadByte = 8'h80;

    typedef enum logic {
        t_MODE_ABSORB = 1'b0,
        t_MODE_FINISH = 1'b1
    } t_mode;

    localparam logic [31:0] InitHash [HashWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

// ----- rtl/core/sha256_stream_hasher_top.sv -----
// Absorb request: when it completes a block, input waits while the block is compressed
// (load, 64 rounds at one round a cycle, fold).
// Finish request: pad/length byte writes and a compression, plus a second block
// when more than 55 bytes are pending; then 8 digest words, one per cycle under i_ready.
// New bytes are not accepted while a block is compressed, as there is a single buffer.
// Synchronous active-low reset restores the initial hash, zero bit count and fill.
module sha256_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic        o_last_word,
    output logic        o_status
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_LEN, ST_LOAD, ST_ROUND, ST_FOLD, ST_OUT
    } t_state;

    // block buffer memory: 16 words of 32 bits, byte writes
    logic [31:0] mem [sha256_pkg::BlockWords];
    logic [31:0] r_mem_q;
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [3:0]  mem_raddr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_wbe;

    t_state      r_state;
    logic [31:0] r_h [sha256_pkg::HashWords];
    logic [31:0] r_v [sha256_pkg::HashWords];
    logic [31:0] r_w [sha256_pkg::BlockWords];
    logic [63:0] r_bits;
    logic [5:0]  r_fill;
    logic [5:0]  r_pos;
    logic [6:0]  r_rnd;
    logic        r_final;
    logic [2:0]  r_oidx;

    logic [31:0] w_cur;
    logic [31:0] w_next;
    logic [31:0] t1;
    logic [31:0] t2;

    assign o_ready = (r_state == ST_IDLE) && !(o_valid);

    // memory write/read
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (mem_we && mem_wbe[b]) begin
                mem[mem_waddr][b*8 +: 8] <= mem_wdata[b*8 +: 8];
            end
        end
        r_mem_q <= mem[mem_raddr];
    end

    // byte lane write helper
    logic [7:0] wr_byte;
    logic [5:0] wr_pos;
    logic       byte_we;
    always_comb begin
        mem_waddr = wr_pos[5:2];
        mem_wdata = {4{wr_byte}};
        mem_wbe   = 4'b0001 << (2'd3 - wr_pos[1:0]);
        mem_we    = byte_we;
    end

    // message schedule word for this round
    assign w_cur  = (r_rnd < 7'd16) ? r_mem_q : w_next;
    assign w_next = sha256_pkg::sig1(r_w[14]) + r_w[9] + sha256_pkg::sig0(r_w[1]) + r_w[0];
    assign t1 = r_v[7] + sha256_pkg::bsig1(r_v[4])
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha256_pkg::RoundK[r_rnd[5:0]] + w_cur;
    assign t2 = sha256_pkg::bsig0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    logic acc;
    assign acc = i_valid && o_ready;

    always_comb begin
        byte_we   = 1'b0;
        wr_byte   = i_data_byte;
        wr_pos    = r_fill;
        mem_raddr = r_rnd[3:0] + 4'd1;
        case (r_state)
            ST_IDLE: begin
                mem_raddr = 4'd0;
                if (acc && i_mode == sha256_pkg::t_MODE_ABSORB && r_bits < 64'hffff_ffff_ffff_fff8) begin
                    byte_we = 1'b1;
                end
                if (acc && i_mode == sha256_pkg::t_MODE_FINISH) begin
                    byte_we = 1'b1;
                    wr_byte = sha256_pkg::PadByte;
                end
            end
            ST_PAD: begin
                mem_raddr = 4'd0;
                byte_we = 1'b1;
                wr_byte = 8'h00;
                wr_pos  = r_pos;
            end
            ST_LEN: begin
                mem_raddr = 4'd0;
                byte_we = 1'b1;
                wr_pos  = r_pos;
                wr_byte = r_bits[{3'd7 - r_pos[2:0], 3'b000} +: 8];
            end
            ST_LOAD: mem_raddr = 4'd0;
            default: ;
        endcase
    end

    // control, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bits  <= '0;
            r_fill  <= '0;
            r_final <= 1'b0;
            r_oidx  <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < sha256_pkg::HashWords; i++) r_h[i] <= sha256_pkg::InitHash[i];
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_valid && i_ready) o_valid <= 1'b0;
                    if (acc) begin
                        if (i_mode == sha256_pkg::t_MODE_ABSORB) begin
                            if (r_bits >= 64'hffff_ffff_ffff_fff8) begin
                                o_valid <= 1'b1;
                                o_digest_word <= '0;
                                o_last_word   <= 1'b1;
                                o_status      <= 1'b1;
                            end else begin
                                r_bits <= r_bits + 64'd8;
                                r_fill <= r_fill + 6'd1;
                                if (r_fill == 6'd63) begin
                                    r_final <= 1'b0;
                                    r_state <= ST_LOAD;
                                end
                            end
                        end else begin
                            // pad byte at fill; 55 lands straight on the length field
                            r_pos   <= r_fill + 6'd1;
                            r_final <= (r_fill < 6'd56);
                            if (r_fill == 6'd63) r_state <= ST_LOAD;
                            else if (r_fill == 6'd55) r_state <= ST_LEN;
                            else r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_pos <= r_pos + 6'd1;
                    if (r_final && r_pos == 6'd55) r_state <= ST_LEN;
                    if (!r_final && r_pos == 6'd63) r_state <= ST_LOAD;
                end
                ST_LEN: begin
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    for (int i = 0; i < sha256_pkg::HashWords; i++) r_v[i] <= r_h[i];
                    r_rnd   <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= (r_rnd < 7'd16) ? r_mem_q : w_next;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 7'd1;
                    if (r_rnd == 7'd63) r_state <= ST_FOLD;
                end
                ST_FOLD: begin
                    for (int i = 0; i < sha256_pkg::HashWords; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_fill <= '0;
                    // last block of a message, extra length block, or plain absorb
                    if (r_final) begin
                        r_oidx  <= '0;
                        r_state <= ST_OUT;
                    end else if (r_fill != 6'd0) begin
                        r_pos   <= '0;
                        r_final <= 1'b1;
                        r_state <= ST_PAD;
                    end else r_state <= ST_IDLE;
                end
                ST_OUT: begin
                    if (!o_valid || i_ready) begin
                        if (o_valid && o_last_word) begin
                            o_valid <= 1'b0;
                            r_bits  <= '0;
                            r_fill  <= '0;
                            for (int i = 0; i < sha256_pkg::HashWords; i++)
                                r_h[i] <= sha256_pkg::InitHash[i];
                            r_state <= ST_IDLE;
                        end else begin
                            o_valid       <= 1'b1;
                            o_digest_word <= r_h[r_oidx];
                            o_last_word   <= (r_oidx == 3'd7);
                            o_status      <= 1'b0;
                            r_oidx        <= r_oidx + 3'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/sha256_checker.sv -----
module sha256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word,
    input logic        o_last_word,
    input logic        o_status
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_word))
        else $error("result changed while stalled");

    // error results are always single and zero
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last_word && o_digest_word == 32'd0)
        else $error("malformed error result");

    // no new request while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while result pending");

endmodule

bind sha256_stream_hasher_top sha256_checker u_chk (.*);
